@@ rtl/fpv_pkg.sv @@
`timescale 1ns / 1ps
package fpv_pkg;

  localparam int COUNT_BITS_DEF   = 10;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int SUM_INT_BITS_DEF = 22;

  // high segment scale 320.5 / 135.4 as a ratio of integers
  localparam int HI_START    = 136;
  localparam int HI_NUM      = 3205;
  localparam int HI_NUM_BITS = 12;
  localparam int HI_DEN      = 1354;
  localparam int HI_DEN_BITS = 11;

  // chunk width of the constant multiplier for the high segment
  localparam int PP_BITS = 24;

  localparam int MIN_EMIT_ML = 2;

  // low segments held as mL in Q.5, which also covers 16.6/3.2 at a count of three
  localparam int LO_Q_BITS     = 5;
  localparam int LO_ENTRY_BITS = 14;
  localparam int LO_DEPTH      = HI_START;
  localparam int LO_IDX_BITS   = 8;
  localparam int LO_COUNT      = 3;
  localparam int LO_COUNT_Q5   = 3 * 166;

  typedef logic [LO_ENTRY_BITS-1:0] lo_table_t [LO_DEPTH];

  typedef struct packed {
    logic valid;
    logic last;
  } vol_ctl_t;

  // map() with truncated breakpoints, evaluated at elaboration only
  function automatic lo_table_t build_lo_table();
    lo_table_t t;
    int ml;
    for (int i = 0; i < LO_DEPTH; i++) begin
      if (i >= 72) begin
        ml = (i - 71) * 145 / 64 + 175;
      end else if (i >= 41) begin
        ml = (i - 40) * 72 / 31 + 103;
      end else if (i >= 14) begin
        ml = (i - 14) * 59 / 26 + 44;
      end else if (i >= 4) begin
        ml = (i - 3) * 28 / 11 + 16;
      end else begin
        ml = 0;
      end
      if (i == LO_COUNT) begin
        t[i] = LO_ENTRY_BITS'(LO_COUNT_Q5);
      end else begin
        t[i] = LO_ENTRY_BITS'(ml << LO_Q_BITS);
      end
    end
    return t;
  endfunction

  localparam lo_table_t LO_TABLE = build_lo_table();

endpackage

@@ rtl/fpv_window_volume.sv @@
`timescale 1ns / 1ps
module fpv_window_volume #(
  parameter int COUNT_BITS = fpv_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = fpv_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [COUNT_BITS-1:0]           pulse_count,
  input  logic                            window_last,
  output fpv_pkg::vol_ctl_t               out_ctl,
  output logic [COUNT_BITS+FRAC_BITS+1:0] volume,
  input  logic                            out_ready
);
  import fpv_pkg::*;

  localparam int VW     = COUNT_BITS + 2 + FRAC_BITS;
  localparam int N_BITS = COUNT_BITS + HI_NUM_BITS + FRAC_BITS;
  localparam int S      = N_BITS + HI_DEN_BITS;
  localparam int SHIFT  = S - FRAC_BITS;
  localparam int KW     = S + 2;
  localparam int NCH    = (KW + PP_BITS - 1) / PP_BITS;
  localparam int PPW    = COUNT_BITS + PP_BITS;
  localparam int TW     = COUNT_BITS + NCH * PP_BITS;

  // floor(x / 1354) == (x * RECIP) >> S for every x below 2^N_BITS
  localparam logic [127:0] RECIP = ((128'd1 << S) + 128'(HI_DEN) - 128'd1) / 128'(HI_DEN);
  localparam logic [127:0] KMUL  = RECIP * 128'(HI_NUM);
  localparam logic [NCH*PP_BITS-1:0] KPAD = KMUL[NCH*PP_BITS-1:0];
  localparam int LO_SHIFT = FRAC_BITS - LO_Q_BITS;

  logic                     s1_valid, s1_ready, s1_hi, s1_last;
  logic [PPW-1:0]           pp [NCH];
  logic [LO_ENTRY_BITS-1:0] s1_lo;
  logic                     s2_valid, s2_ready, s2_last;
  logic                     is_hi;
  logic [LO_IDX_BITS-1:0]   lo_idx;
  logic [TW-1:0]            acc;
  logic [VW-1:0]            volume_next;

  assign s2_ready = !s2_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  assign is_hi  = pulse_count >= COUNT_BITS'(HI_START);
  assign lo_idx = is_hi ? '0 : pulse_count[LO_IDX_BITS-1:0];

  always_comb begin
    acc = '0;
    for (int i = 0; i < NCH; i++) begin
      acc = acc + (TW'(pp[i]) << (i * PP_BITS));
    end
    if (s1_hi) begin
      volume_next = acc[SHIFT +: VW];
    end else begin
      volume_next = VW'(s1_lo) << LO_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      for (int i = 0; i < NCH; i++) begin
        pp[i] <= PPW'(pulse_count) * PPW'(KPAD[i*PP_BITS +: PP_BITS]);
      end
      s1_lo   <= LO_TABLE[lo_idx];
      s1_hi   <= is_hi;
      s1_last <= window_last;
    end
    if (s1_valid && s2_ready) begin
      volume  <= volume_next;
      s2_last <= s1_last;
    end
  end

  assign out_ctl.valid = s2_valid;
  assign out_ctl.last  = s2_last;

endmodule

@@ rtl/fpv_accum.sv @@
`timescale 1ns / 1ps
module fpv_accum #(
  parameter int COUNT_BITS   = fpv_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS    = fpv_pkg::FRAC_BITS_DEF,
  parameter int SUM_INT_BITS = fpv_pkg::SUM_INT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  fpv_pkg::vol_ctl_t                 in_ctl,
  input  logic [COUNT_BITS+FRAC_BITS+1:0]   in_volume,
  output logic                              in_ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [SUM_INT_BITS+FRAC_BITS-1:0] volume_q16,
  output logic                              saturated
);
  import fpv_pkg::*;

  localparam int VW       = COUNT_BITS + 2 + FRAC_BITS;
  localparam int SUM_BITS = SUM_INT_BITS + FRAC_BITS;
  localparam int CMPW     = (VW > SUM_BITS) ? VW : SUM_BITS;
  localparam logic [SUM_BITS-1:0] SUM_MAX  = '1;
  localparam logic [SUM_BITS-1:0] EMIT_MIN = SUM_BITS'(MIN_EMIT_ML) << FRAC_BITS;

  logic [SUM_BITS-1:0] sum, sum_next, emit_value;
  logic                clipped, clipped_next;
  logic                take;
  logic [CMPW-1:0]     room, vin;

  // only a last item needs the result slot
  assign in_ready = !in_ctl.last || !out_valid || out_ready;
  assign take     = in_ctl.valid && in_ready;

  assign room = CMPW'(SUM_MAX - sum);
  assign vin  = CMPW'(in_volume);

  always_comb begin
    if (vin > room) begin
      sum_next     = SUM_MAX;
      clipped_next = 1'b1;
    end else begin
      sum_next     = sum + SUM_BITS'(vin);
      clipped_next = clipped;
    end
    emit_value = (sum_next < EMIT_MIN) ? '0 : sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      clipped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take && in_ctl.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (in_ctl.last) begin
          sum     <= '0;
          clipped <= 1'b0;
        end else begin
          sum     <= sum_next;
          clipped <= clipped_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_ctl.last) begin
      volume_q16 <= emit_value;
      saturated  <= clipped_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    take && in_ctl.last |=> sum == '0 && !clipped)
    else $error("sum not cleared after last item");

  a_clip_holds_max: assert property (@(posedge clk) disable iff (rst)
    clipped |-> sum == SUM_MAX)
    else $error("clipped flag set but sum below maximum");

  a_sat_result_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> volume_q16 == SUM_MAX)
    else $error("saturated result not at maximum");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("pending result dropped");
`endif

endmodule

@@ rtl/flow_pulse_piecewise_volume.sv @@
`timescale 1ns / 1ps
// channel  | handshake             | payload
// input    | in_valid / in_ready   | pulse_count, window_last
// result   | out_valid / out_ready | volume_q16, saturated
//
// One item per cycle unless a last item waits on the result register; the last item
// passes a partial-product stage for the high-count scaling, a sum-and-select
// stage, then the saturating accumulator, whose result register offers the result.
// Reset clears the pipeline valids, the running sum and the clip flag.
// Items not marked last flow into the sum even while a result waits; a last item
// holds at the accumulator until the result register is free.
module flow_pulse_piecewise_volume #(
  parameter int COUNT_BITS   = fpv_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS    = fpv_pkg::FRAC_BITS_DEF,
  parameter int SUM_INT_BITS = fpv_pkg::SUM_INT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [COUNT_BITS-1:0]             pulse_count,
  input  logic                              window_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [SUM_INT_BITS+FRAC_BITS-1:0] volume_q16,
  output logic                              saturated
);
  import fpv_pkg::*;

  vol_ctl_t                        win_ctl;
  logic [COUNT_BITS+FRAC_BITS+1:0] win_volume;
  logic                            acc_ready;

  fpv_window_volume #(
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pulse_count (pulse_count),
    .window_last (window_last),
    .out_ctl     (win_ctl),
    .volume      (win_volume),
    .out_ready   (acc_ready)
  );

  fpv_accum #(
    .COUNT_BITS   (COUNT_BITS),
    .FRAC_BITS    (FRAC_BITS),
    .SUM_INT_BITS (SUM_INT_BITS)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .in_ctl     (win_ctl),
    .in_volume  (win_volume),
    .in_ready   (acc_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .volume_q16 (volume_q16),
    .saturated  (saturated)
  );

endmodule
